### design/sqmm_pkg.sv
// ----------------------------------------------------------------------------
// sqmm_pkg
// Shared widths, command codes and the queued transaction type for the
// square matrix column multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sqmm_pkg;

  // Field widths
  localparam int ROW_W   = 3;   // row / column index fields
  localparam int VAL_W   = 32;  // Q16.16 values
  localparam int FRAC_W  = 16;  // fractional bits
  localparam int CADDR_W = 6;   // coefficient address, largest matrix is 8x8

  // Defaults and sizing
  localparam int DIM_DEFAULT = 3;
  localparam int QUEUE_DEPTH = 4;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ELEM = 1'b1;

  // Classified transaction passed from front end to back end
  typedef struct packed {
    logic                    is_elem;   // column element, else coefficient load
    logic                    ends_col;  // element with the last index
    logic [CADDR_W-1:0]      caddr;     // coefficient address row*DIM+col
    logic [ROW_W-1:0]        row;       // element index within the column
    logic signed [VAL_W-1:0] value;
  } item_t;

endpackage

### design/sqmm_in_if.sv
// ----------------------------------------------------------------------------
// sqmm_in_if
// Input channel: coefficient loads and column elements.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sqmm_in_if;
  import sqmm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [ROW_W-1:0]        row_index;
  logic [ROW_W-1:0]        col_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, cmd, row_index, col_index, value, input ready);
  modport sink   (input valid, cmd, row_index, col_index, value, output ready);
endinterface

### design/sqmm_out_if.sv
// ----------------------------------------------------------------------------
// sqmm_out_if
// Output channel: elements of the product column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sqmm_out_if;
  import sqmm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result;
  logic [ROW_W-1:0]        out_row;
  logic                    last;

  modport source (output valid, result, out_row, last, input ready);
  modport sink   (input valid, result, out_row, last, output ready);
endinterface

### design/square_matrix_column_multiply.sv
// ----------------------------------------------------------------------------
// square_matrix_column_multiply
// Once the completing B element is accepted, C elements pass through the read,
// multiply, accumulate and output registers and leave in row order.
// One shared MAC computes every C element; the back end takes no new load or
// element until all DIM*DIM terms of a column have been issued.
// Reset clears the queue and pipeline; A and B stores are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module square_matrix_column_multiply #(
  parameter int DIM = sqmm_pkg::DIM_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  sqmm_in_if.sink    item,
  sqmm_out_if.source product
);
  import sqmm_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // Classify incoming transactions
  sqmm_front #(.DIM(DIM)) u_front (
    .item       (item),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Decoupling queue
  sqmm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // Stores and multiply-accumulate
  sqmm_back #(.DIM(DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .product   (product)
  );

endmodule

### design/sqmm_front.sv
// ----------------------------------------------------------------------------
// sqmm_front
// Accepts input transactions, drops out-of-range indexes, computes the
// coefficient address and flags the element that completes a column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqmm_front #(
  parameter int DIM = sqmm_pkg::DIM_DEFAULT
) (
  sqmm_in_if.sink          item,
  output logic             push_valid,
  output sqmm_pkg::item_t  push_item,
  input  logic             push_ready
);
  import sqmm_pkg::*;

  localparam logic [ROW_W:0]   DIM_LIM  = (ROW_W + 1)'(DIM);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DIM - 1);

  logic row_ok;
  logic col_ok;
  logic in_range;

  // Range check; col_index only matters for loads
  assign row_ok   = {1'b0, item.row_index} < DIM_LIM;
  assign col_ok   = {1'b0, item.col_index} < DIM_LIM;
  assign in_range = (item.cmd == CMD_ELEM) ? row_ok : (row_ok && col_ok);

  // Out-of-range transactions are taken and dropped
  assign item.ready = push_ready;
  assign push_valid = item.valid && in_range;

  // Classification
  always_comb begin
    push_item.is_elem  = (item.cmd == CMD_ELEM);
    push_item.ends_col = (item.cmd == CMD_ELEM) && (item.row_index == LAST_ROW);
    push_item.caddr    = CADDR_W'(int'(item.row_index) * DIM + int'(item.col_index));
    push_item.row      = item.row_index;
    push_item.value    = item.value;
  end

endmodule

### design/sqmm_queue.sv
// ----------------------------------------------------------------------------
// sqmm_queue
// Small FIFO between front and back end so either side can stall alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqmm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  sqmm_pkg::item_t  push_item,
  output logic             push_ready,
  output logic             pop_valid,
  output sqmm_pkg::item_t  pop_item,
  input  logic             pop_ready
);
  import sqmm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### design/sqmm_back.sv
// ----------------------------------------------------------------------------
// sqmm_back
// Holds the coefficient store and column buffer, and runs one shared
// multiply-accumulate over DIM*DIM terms when a column completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqmm_back #(
  parameter int DIM = sqmm_pkg::DIM_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  sqmm_pkg::item_t  pop_item,
  output logic             pop_ready,
  sqmm_out_if.source       product
);
  import sqmm_pkg::*;

  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W = (DIM > 1) ? $clog2(DIM * DIM) : 1;
  localparam int CNT_W  = $clog2(DIM + 1);
  localparam int ACC_W  = 2 * VAL_W + CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'({1'b0, {(VAL_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  // Stores
  logic signed [VAL_W-1:0] coef_mem [DIM*DIM];
  logic signed [VAL_W-1:0] col_buf  [DIM];

  // Sequencer
  logic              busy;
  logic [IDX_W-1:0]  i_cnt;
  logic [IDX_W-1:0]  k_cnt;
  logic [ADDR_W-1:0] caddr;
  logic              take;
  logic              en;

  // Read stage
  logic                    s1_v;
  logic                    s1_first;
  logic                    s1_lastk;
  logic [IDX_W-1:0]        s1_row;
  logic signed [VAL_W-1:0] coef_rd;
  logic signed [VAL_W-1:0] col_rd;

  // Multiply stage
  logic                      s2_v;
  logic                      s2_first;
  logic                      s2_lastk;
  logic [IDX_W-1:0]          s2_row;
  logic signed [2*VAL_W-1:0] prod;

  // Accumulate stage
  logic                    s3_done;
  logic [IDX_W-1:0]        s3_row;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic signed [VAL_W-1:0] sat_val;

  // Whole pipeline advances unless a finished result is waiting
  assign en        = !product.valid || product.ready;
  assign pop_ready = !busy;
  assign take      = pop_valid && !busy;

  // Coefficient store: write on load, registered read while issuing
  always_ff @(posedge clk) begin
    if (take && !pop_item.is_elem) begin
      coef_mem[pop_item.caddr[ADDR_W-1:0]] <= pop_item.value;
    end
    if (en && busy) begin
      coef_rd <= coef_mem[caddr];
    end
  end

  // Column buffer: write on element, registered read while issuing
  always_ff @(posedge clk) begin
    if (take && pop_item.is_elem) begin
      col_buf[pop_item.row[IDX_W-1:0]] <= pop_item.value;
    end
    if (en && busy) begin
      col_rd <= col_buf[k_cnt];
    end
  end

  // Issue sequencer: rows i, terms k
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      i_cnt <= '0;
      k_cnt <= '0;
      caddr <= '0;
    end else if (take) begin
      if (pop_item.ends_col) begin
        busy  <= 1'b1;
        i_cnt <= '0;
        k_cnt <= '0;
        caddr <= '0;
      end
    end else if (busy && en) begin
      caddr <= caddr + ADDR_W'(1);
      if (k_cnt == LAST_IDX) begin
        k_cnt <= '0;
        i_cnt <= i_cnt + IDX_W'(1);
        if (i_cnt == LAST_IDX) busy <= 1'b0;
      end else begin
        k_cnt <= k_cnt + IDX_W'(1);
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      s3_done       <= 1'b0;
      product.valid <= 1'b0;
    end else if (en) begin
      s1_v          <= busy;
      s2_v          <= s1_v;
      s3_done       <= s2_v && s2_lastk;
      product.valid <= s3_done;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_first <= (k_cnt == '0);
      s1_lastk <= (k_cnt == LAST_IDX);
      s1_row   <= i_cnt;

      s2_first <= s1_first;
      s2_lastk <= s1_lastk;
      s2_row   <= s1_row;
      prod     <= coef_rd * col_rd;

      if (s2_v) begin
        acc <= s2_first ? ACC_W'(prod) : acc + ACC_W'(prod);
      end
      s3_row <= s2_row;

      product.result  <= sat_val;
      product.out_row <= ROW_W'(s3_row);
      product.last    <= (s3_row == LAST_IDX);
    end
  end

  // Floor shift back to Q16.16 and saturate
  always_comb begin
    shifted = acc >>> FRAC_W;
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI[VAL_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO[VAL_W-1:0];
    end else begin
      sat_val = shifted[VAL_W-1:0];
    end
  end

endmodule

### bench/tb_square_matrix_column_multiply.sv
// ----------------------------------------------------------------------------
// tb_square_matrix_column_multiply
// Self-checking bench for the square matrix column multiplier. Loads A
// coefficients, streams B columns under random valid/ready pressure and
// compares every C element with a Q16.16 dot-product predictor kept in a
// small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_square_matrix_column_multiply;
  import sqmm_pkg::*;

  localparam int DIM          = DIM_DEFAULT;
  localparam int HOLD_CYCLES  = 300;   // long output hold-off
  localparam int STALL_LIMIT  = 4000;  // cycles with no transaction on either side
  localparam int RANDOM_ITEMS = 260;

  typedef struct packed {
    logic signed [VAL_W-1:0] result;
    logic [ROW_W-1:0]        out_row;
    logic                    last;
  } c_elem_t;

  // Predicts C columns from its own copy of A and the B column buffer
  class product_column_checker;
    logic signed [VAL_W-1:0] coef_a [DIM*DIM];
    logic signed [VAL_W-1:0] col_b [DIM];
    c_elem_t                 pending_c[$];
    int                      errors;

    function new();
      errors = 0;
      foreach (coef_a[i]) coef_a[i] = '0;
      foreach (col_b[i]) col_b[i] = '0;
    endfunction

    function int pending();
      return pending_c.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Row i of A times the buffered column: exact sum, floor shift, saturate
    function logic signed [VAL_W-1:0] dot_row(int i);
      logic signed [67:0] acc;
      logic signed [67:0] a_term;
      logic signed [67:0] b_term;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        a_term = coef_a[i*DIM + k];
        b_term = col_b[k];
        acc += a_term * b_term;
      end
      acc = acc >>> FRAC_W;
      if (acc > 68'sd2147483647) return 32'sh7FFF_FFFF;
      if (acc < -68'sd2147483648) return 32'sh8000_0000;
      return acc[VAL_W-1:0];
    endfunction

    // Accepted input transaction: update state, queue C column on completion
    function void note_item(logic cmd, logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                            logic signed [VAL_W-1:0] value);
      c_elem_t e;
      if (cmd == CMD_LOAD) begin
        if (row < DIM && col < DIM) coef_a[row*DIM + col] = value;
        return;
      end
      if (row >= DIM) return;
      col_b[row] = value;
      if (row != DIM - 1) return;
      for (int i = 0; i < DIM; i++) begin
        e.result  = dot_row(i);
        e.out_row = ROW_W'(i);
        e.last    = (i == DIM - 1);
        pending_c.push_back(e);
      end
    endfunction

    // Accepted output transaction against the oldest expected element
    task check_element(logic signed [VAL_W-1:0] result, logic [ROW_W-1:0] out_row,
                       logic last);
      c_elem_t e;
      if (pending_c.size() == 0) begin
        report($sformatf("unexpected result %0d row %0d last %0b", result, out_row, last));
        return;
      end
      e = pending_c.pop_front();
      if (result !== e.result)
        report($sformatf("row %0d result %0d, expected %0d", e.out_row, result, e.result));
      if (out_row !== e.out_row)
        report($sformatf("out_row %0d, expected %0d", out_row, e.out_row));
      if (last !== e.last)
        report($sformatf("row %0d last %0b, expected %0b", e.out_row, last, e.last));
    endtask
  endclass

  logic clk;
  logic rst;
  int   useful_sent;

  product_column_checker sb;

  sqmm_in_if  in_ch ();
  sqmm_out_if out_ch ();

  square_matrix_column_multiply #(.DIM(DIM)) dut (
    .clk     (clk),
    .rst     (rst),
    .item    (in_ch.sink),
    .product (out_ch.source)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random Q16.16 operand: extremes, tiny, moderate or fully random
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(0, 2)) - 32'd1;
      3, 4: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  // Offer one transaction, wait for acceptance, then maybe idle
  task automatic send_item(input logic cmd, input logic [ROW_W-1:0] row,
                           input logic [ROW_W-1:0] col, input logic signed [VAL_W-1:0] value);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.row_index <= row;
    in_ch.col_index <= col;
    in_ch.value     <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(cmd, row, col, value);
    if (cmd == CMD_LOAD ? (row < DIM && col < DIM) : (row < DIM)) useful_sent++;
    // no idling inside the quiet stretch
    if (!(useful_sent >= 100 && useful_sent < 160) && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Output side: random stalls, one quiet stretch, one long hold-off
  initial begin : sink_side
    int taken;
    int hold_left;
    bit held;
    taken     = 0;
    hold_left = 0;
    held      = 1'b0;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held && taken >= 30) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (taken >= 150 && taken < 250) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_element(out_ch.result, out_ch.out_row, out_ch.last);
  end

  // Watchdog: ends the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d idle cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int kind;
    bit drained_once;
    drained_once = 1'b0;
    useful_sent  = 0;
    sb = new();
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_LOAD;
    in_ch.row_index <= '0;
    in_ch.col_index <= '0;
    in_ch.value     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill all of A before any column completes
    send_item(CMD_LOAD, 3'd0, 3'd0, 32'sh7FFF_FFFF);
    send_item(CMD_LOAD, 3'd0, 3'd1, 32'sh7FFF_FFFF);
    send_item(CMD_LOAD, 3'd0, 3'd2, 32'sh0000_0000);
    send_item(CMD_LOAD, 3'd1, 3'd0, 32'sh8000_0000);
    send_item(CMD_LOAD, 3'd1, 3'd1, 32'sh7FFF_FFFF);
    send_item(CMD_LOAD, 3'd1, 3'd2, 32'sh0000_0000);
    send_item(CMD_LOAD, 3'd2, 3'd0, 32'sh0001_0000);
    send_item(CMD_LOAD, 3'd2, 3'd1, 32'shFFFF_0000);
    send_item(CMD_LOAD, 3'd2, 3'd2, 32'sh0000_0001);
    // out-of-range loads are dropped
    send_item(CMD_LOAD, 3'd7, 3'd0, 32'sh1234_5678);
    send_item(CMD_LOAD, 3'd0, 3'd7, 32'sh8765_4321);
    // full column driving row 0 into positive saturation
    send_item(CMD_ELEM, 3'd0, 3'd5, 32'sh7FFF_FFFF);
    send_item(CMD_ELEM, 3'd1, 3'd2, 32'sh7FFF_FFFF);
    send_item(CMD_ELEM, 3'd2, 3'd7, 32'sh8000_0000);
    // out-of-range element is dropped
    send_item(CMD_ELEM, 3'd7, 3'd3, 32'sh0000_007B);
    // load mid-column; element 1 keeps its old value
    send_item(CMD_ELEM, 3'd0, 3'd0, 32'shFFFF_FFFF);
    send_item(CMD_LOAD, 3'd2, 3'd2, 32'shFFFF_FFFD);
    send_item(CMD_ELEM, 3'd2, 3'd1, 32'sh0001_0000);
    // last element alone completes a column
    send_item(CMD_ELEM, 3'd2, 3'd4, 32'sh0002_8000);
    // elements out of order
    send_item(CMD_ELEM, 3'd1, 3'd6, 32'sh0000_0001);
    send_item(CMD_ELEM, 3'd0, 3'd3, 32'sh0000_0000);
    send_item(CMD_ELEM, 3'd2, 3'd0, 32'shFFFF_FFFF);

    // Random: mostly whole columns, some loads, noise and partial columns
    useful_sent = 0;
    while (useful_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        for (int k = 0; k < DIM; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(CMD_LOAD, 3'($urandom_range(0, DIM-1)), 3'($urandom_range(0, DIM-1)),
                      pick_value());
          send_item(CMD_ELEM, 3'(k), 3'($urandom_range(0, 7)), pick_value());
        end
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 4))
          send_item(CMD_LOAD, 3'($urandom_range(0, DIM-1)), 3'($urandom_range(0, DIM-1)),
                    pick_value());
      end else if (kind < 90) begin
        send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), pick_value());
      end else begin
        send_item(CMD_ELEM, 3'($urandom_range(0, DIM-1)), 3'($urandom_range(0, 7)),
                  pick_value());
      end
      // sender pauses once until the block has drained
      if (!drained_once && useful_sent >= 200) begin
        drained_once = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for any stray output
    while (sb.pending() != 0) @(posedge clk);
    repeat (4*DIM + 20) @(posedge clk);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
